// ===== rtl/contained_box_union_query_core_defines.svh =====
// ============================================================================
// Assertion macros for the box union query core
// Shared property forms used by the RTL modules that carry checks.
// ============================================================================
`ifndef CONTAINED_BOX_UNION_QUERY_CORE_DEFINES_SVH
`define CONTAINED_BOX_UNION_QUERY_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CBUQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CBUQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cbuq_pkg.sv =====
// ============================================================================
// cbuq_pkg
// Types and constants shared by the box union query core.
// ============================================================================
package cbuq_pkg;

    localparam int EDGE_W         = 15;
    localparam int END_W          = EDGE_W + 1;
    localparam int AREA_W         = 2 * EDGE_W;
    localparam int MAX_BOXES_DEF  = 256;
    localparam logic [AREA_W-1:0] AREA_FLOOR_RESET = AREA_W'(32);
    localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    // one stored box, 60 bits
    typedef struct packed {
        logic [EDGE_W-1:0] x;
        logic [EDGE_W-1:0] y;
        logic [EDGE_W-1:0] w;
        logic [EDGE_W-1:0] h;
    } box_t;

    // query rectangle with its far edges precomputed
    typedef struct packed {
        logic [EDGE_W-1:0] x;
        logic [EDGE_W-1:0] y;
        logic [END_W-1:0]  r;
        logic [END_W-1:0]  b;
    } query_t;

    // running union and pipeline status from the scan unit
    typedef struct packed {
        logic              busy;
        logic              any;
        logic [EDGE_W-1:0] ul;
        logic [EDGE_W-1:0] ut;
        logic [END_W-1:0]  ur;
        logic [END_W-1:0]  ub;
    } scan_res_t;

endpackage

// ===== rtl/cbuq_box_mem.sv =====
// ============================================================================
// cbuq_box_mem
// Box table: one write port, one read port, registered read data.
// ============================================================================
module cbuq_box_mem
    import cbuq_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF,
    parameter int ADDR_W    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  box_t              wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output box_t              rdata,
    output logic              rvalid
);

    box_t mem [MAX_BOXES];
    box_t rdata_reg;
    logic rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= re;
        end
    end

    assign rdata  = rdata_reg;
    assign rvalid = rvalid_reg;

endmodule

// ===== rtl/cbuq_scan_unit.sv =====
// ============================================================================
// cbuq_scan_unit
// Area and containment test per box, then min/max union accumulation.
// ============================================================================
module cbuq_scan_unit
    import cbuq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  box_t              box,
    input  logic              box_valid,
    input  query_t            query,
    input  logic [AREA_W-1:0] area_floor,
    output scan_res_t         res
);

    // stage A: area product and containment
    logic              a_v_reg;
    logic [AREA_W-1:0] a_area_reg;
    logic              a_fit_reg;
    logic [EDGE_W-1:0] a_bx_reg;
    logic [EDGE_W-1:0] a_by_reg;
    logic [END_W-1:0]  a_br_reg;
    logic [END_W-1:0]  a_bb_reg;

    // union accumulator
    logic              any_reg;
    logic [EDGE_W-1:0] ul_reg;
    logic [EDGE_W-1:0] ut_reg;
    logic [END_W-1:0]  ur_reg;
    logic [END_W-1:0]  ub_reg;

    logic [END_W-1:0]  br;
    logic [END_W-1:0]  bb;
    logic              fit;
    logic              keep;

    assign br  = END_W'(box.x) + END_W'(box.w);
    assign bb  = END_W'(box.y) + END_W'(box.h);
    assign fit = (box.x >= query.x) && (box.y >= query.y)
              && (br <= query.r) && (bb <= query.b);
    assign keep = a_v_reg && a_fit_reg && (a_area_reg >= area_floor);

    always_ff @(posedge clk)
    begin
        a_area_reg <= AREA_W'(box.w) * AREA_W'(box.h);
        a_fit_reg  <= fit;
        a_bx_reg   <= box.x;
        a_by_reg   <= box.y;
        a_br_reg   <= br;
        a_bb_reg   <= bb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            any_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= box_valid;
            if (start)
            begin
                any_reg <= 1'b0;
            end
            else if (keep)
            begin
                any_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            // first kept box seeds the union
            if (!any_reg || a_bx_reg < ul_reg) ul_reg <= a_bx_reg;
            if (!any_reg || a_by_reg < ut_reg) ut_reg <= a_by_reg;
            if (!any_reg || a_br_reg > ur_reg) ur_reg <= a_br_reg;
            if (!any_reg || a_bb_reg > ub_reg) ub_reg <= a_bb_reg;
        end
    end

    assign res = '{busy: a_v_reg, any: any_reg, ul: ul_reg, ut: ut_reg,
                   ur: ur_reg, ub: ub_reg};

endmodule

// ===== rtl/contained_box_union_query_core.sv =====
// ============================================================================
// contained_box_union_query_core
// Box table with a containment-filtered bounding union query.
// ============================================================================
// Clear and load items complete without leaving the idle state. A query
// item scans the stored boxes through the table's single read port, one
// entry per cycle, and stalls the input through the reads, the draining of
// the read and test pipeline, the close of the scan and the forming of the
// result. A finished result waits in the output register while the next
// item is accepted. There is no clearing pass after reset; entries are only
// read after a load has written them.
module contained_box_union_query_core
    import cbuq_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [EDGE_W-1:0] rect_x,
    input  logic [EDGE_W-1:0] rect_y,
    input  logic [EDGE_W-1:0] rect_w,
    input  logic [EDGE_W-1:0] rect_h,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [EDGE_W-1:0] out_x,
    output logic [EDGE_W-1:0] out_y,
    output logic [EDGE_W-1:0] out_w,
    output logic [EDGE_W-1:0] out_h,
    output logic              found,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [AREA_W-1:0] cfg_data
);

`include "contained_box_union_query_core_defines.svh"

    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BOXES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  box_count_reg, box_count_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [AREA_W-1:0] area_floor_reg;
    query_t            query_reg, query_next;
    logic [EDGE_W-1:0] q_w_reg, q_w_next;
    logic [EDGE_W-1:0] q_h_reg, q_h_next;
    logic              out_valid_reg, out_valid_next;
    logic [EDGE_W-1:0] out_x_reg, out_x_next;
    logic [EDGE_W-1:0] out_y_reg, out_y_next;
    logic [EDGE_W-1:0] out_w_reg, out_w_next;
    logic [EDGE_W-1:0] out_h_reg, out_h_next;
    logic              found_reg, found_next;

    logic              in_acc;
    logic              mem_we;
    logic              mem_re;
    box_t              rd_box;
    logic              rd_valid;
    logic              scan_start;
    scan_res_t         scan_res;
    logic [END_W-1:0]  span_w;
    logic [END_W-1:0]  span_h;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    cbuq_box_mem #(
        .MAX_BOXES (MAX_BOXES),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (mem_we),
        .waddr  (box_count_reg[ADDR_W-1:0]),
        .wdata  ('{x: rect_x, y: rect_y, w: rect_w, h: rect_h}),
        .re     (mem_re),
        .raddr  (scan_idx_reg[ADDR_W-1:0]),
        .rdata  (rd_box),
        .rvalid (rd_valid)
    );

    cbuq_scan_unit u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .box        (rd_box),
        .box_valid  (rd_valid),
        .query      (query_reg),
        .area_floor (area_floor_reg),
        .res        (scan_res)
    );

    assign span_w = scan_res.ur - END_W'(scan_res.ul);
    assign span_h = scan_res.ub - END_W'(scan_res.ut);

    always_comb
    begin
        state_next     = state_reg;
        box_count_next = box_count_reg;
        scan_idx_next  = scan_idx_reg;
        query_next     = query_reg;
        q_w_next       = q_w_reg;
        q_h_next       = q_h_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_w_next     = out_w_reg;
        out_h_next     = out_h_reg;
        found_next     = found_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        scan_start     = 1'b0;

        // drop a delivered result
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (opcode)
                        OP_CLEAR:
                        begin
                            box_count_next = '0;
                        end
                        OP_LOAD:
                        begin
                            if (box_count_reg != CNT_FULL)
                            begin
                                mem_we         = 1'b1;
                                box_count_next = box_count_reg + 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            query_next = '{x: rect_x, y: rect_y,
                                           r: END_W'(rect_x) + END_W'(rect_w),
                                           b: END_W'(rect_y) + END_W'(rect_h)};
                            q_w_next      = rect_w;
                            q_h_next      = rect_h;
                            scan_idx_next = '0;
                            scan_start    = 1'b1;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg < box_count_reg)
                begin
                    mem_re        = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (!rd_valid && !scan_res.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (scan_res.any)
                    begin
                        out_x_next = scan_res.ul;
                        out_y_next = scan_res.ut;
                        out_w_next = span_w[EDGE_W] ? EDGE_MAX : span_w[EDGE_W-1:0];
                        out_h_next = span_h[EDGE_W] ? EDGE_MAX : span_h[EDGE_W-1:0];
                        found_next = 1'b1;
                    end
                    else
                    begin
                        out_x_next = query_reg.x;
                        out_y_next = query_reg.y;
                        out_w_next = q_w_reg;
                        out_h_next = q_h_reg;
                        found_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            box_count_reg  <= '0;
            scan_idx_reg   <= '0;
            area_floor_reg <= AREA_FLOOR_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            box_count_reg <= box_count_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                area_floor_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg <= query_next;
        q_w_reg   <= q_w_next;
        q_h_reg   <= q_h_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_w_reg <= out_w_next;
        out_h_reg <= out_h_next;
        found_reg <= found_next;
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_w     = out_w_reg;
    assign out_h     = out_h_reg;
    assign found     = found_reg;

    `CBUQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, box_count_reg <= CNT_FULL,
        "box count past table capacity")
    `CBUQ_ASSERT_SAME(a_scan_bound, clk, rst_n, state_reg == ST_SCAN,
        scan_idx_reg <= box_count_reg, "scan index past box count")
    `CBUQ_ASSERT_SAME(a_read_in_scan, clk, rst_n, rd_valid || scan_res.busy,
        state_reg == ST_SCAN, "table read data outside a scan")
    `CBUQ_ASSERT_NEXT(a_full_load, clk, rst_n,
        in_acc && opcode == OP_LOAD && box_count_reg == CNT_FULL,
        box_count_reg == CNT_FULL, "load into full table changed the count")

endmodule

// ===== dv/box_union_checker.sv =====
// ============================================================================
// box_union_checker
// Watches the item, result and register channels of the box union query
// core. Keeps its own box table and area floor copy, predicts one union per
// query and compares each result in order against the oldest prediction.
// ============================================================================
module box_union_checker
    import cbuq_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [EDGE_W-1:0] rect_x,
    input  logic [EDGE_W-1:0] rect_y,
    input  logic [EDGE_W-1:0] rect_w,
    input  logic [EDGE_W-1:0] rect_h,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [EDGE_W-1:0] out_x,
    input  logic [EDGE_W-1:0] out_y,
    input  logic [EDGE_W-1:0] out_w,
    input  logic [EDGE_W-1:0] out_h,
    input  logic              found,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [AREA_W-1:0] cfg_data,
    output int                fails,
    output int                waiting
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [EDGE_W-1:0] x;
        logic [EDGE_W-1:0] y;
        logic [EDGE_W-1:0] w;
        logic [EDGE_W-1:0] h;
        logic              hit;
    } union_t;

    box_t              box_table [MAX_BOXES];
    int                box_count;
    logic [AREA_W-1:0] area_floor;
    union_t            pending_unions [$];
    union_t            want;

    function automatic logic [EDGE_W-1:0] clamp_span(logic [END_W-1:0] span);
        return (span > END_W'(EDGE_MAX)) ? EDGE_MAX : span[EDGE_W-1:0];
    endfunction

    // bounding union of every stored box that is big enough and lies inside q
    function automatic union_t scan_union(box_t q);
        logic [END_W-1:0]  q_right;
        logic [END_W-1:0]  q_bottom;
        logic [END_W-1:0]  b_right;
        logic [END_W-1:0]  b_bottom;
        logic [END_W-1:0]  u_right;
        logic [END_W-1:0]  u_bottom;
        logic [EDGE_W-1:0] u_left;
        logic [EDGE_W-1:0] u_top;
        logic [AREA_W-1:0] area;
        logic              any;
        box_t              b;
        union_t            res;
        q_right  = END_W'(q.x) + END_W'(q.w);
        q_bottom = END_W'(q.y) + END_W'(q.h);
        any      = 1'b0;
        u_left   = '0;
        u_top    = '0;
        u_right  = '0;
        u_bottom = '0;
        for (int i = 0; i < box_count; i++)
        begin
            b        = box_table[i];
            area     = AREA_W'(b.w) * AREA_W'(b.h);
            b_right  = END_W'(b.x) + END_W'(b.w);
            b_bottom = END_W'(b.y) + END_W'(b.h);
            if (area >= area_floor && b.x >= q.x && b.y >= q.y &&
                b_right <= q_right && b_bottom <= q_bottom)
            begin
                if (!any)
                begin
                    u_left   = b.x;
                    u_top    = b.y;
                    u_right  = b_right;
                    u_bottom = b_bottom;
                end
                else
                begin
                    if (b.x < u_left) u_left = b.x;
                    if (b.y < u_top) u_top = b.y;
                    if (b_right > u_right) u_right = b_right;
                    if (b_bottom > u_bottom) u_bottom = b_bottom;
                end
                any = 1'b1;
            end
        end
        if (any)
        begin
            res.x   = u_left;
            res.y   = u_top;
            res.w   = clamp_span(u_right - END_W'(u_left));
            res.h   = clamp_span(u_bottom - END_W'(u_top));
            res.hit = 1'b1;
        end
        else
        begin
            res.x   = q.x;
            res.y   = q.y;
            res.w   = q.w;
            res.h   = q.h;
            res.hit = 1'b0;
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [EDGE_W-1:0] exp_v,
                               logic [EDGE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_count  = 0;
            area_floor = AREA_FLOOR_RESET;
            pending_unions.delete();
            waiting    = 0;
            fails      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                area_floor = cfg_data;
            // predict first so that an older result still pops first
            if (in_valid && !in_stall)
            begin
                case (opcode)
                    OP_CLEAR: box_count = 0;
                    OP_LOAD:
                    begin
                        if (box_count < MAX_BOXES)
                        begin
                            box_table[box_count] = {rect_x, rect_y, rect_w, rect_h};
                            box_count++;
                        end
                    end
                    OP_QUERY:
                    begin
                        pending_unions = {pending_unions,
                                          scan_union({rect_x, rect_y, rect_w, rect_h})};
                        waiting++;
                    end
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_unions.size() == 0)
                begin
                    $display("%0t: result with none expected: x=%0d y=%0d w=%0d h=%0d found=%0d",
                             $time, out_x, out_y, out_w, out_h, found);
                    fails++;
                end
                else
                begin
                    want = pending_unions.pop_front();
                    waiting--;
                    check_field("out_x", want.x, out_x);
                    check_field("out_y", want.y, out_y);
                    check_field("out_w", want.w, out_w);
                    check_field("out_h", want.h, out_h);
                    check_field("found", EDGE_W'(want.hit), EDGE_W'(found));
                end
            end
        end
    end

endmodule

// ===== dv/contained_box_union_query_core_test.sv =====
// ============================================================================
// contained_box_union_query_core_test
// Drives box table loads, clears and containment queries into the core under
// several area floor settings, with random gaps and stalls on both channels,
// and gives the verdict from the checker's failure and outstanding counts.
// ============================================================================
module contained_box_union_query_core_test
    import cbuq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_BOXES   = MAX_BOXES_DEF;
    localparam int          IDLE_LIMIT  = 20000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_WAIT  = MAX_BOXES + 8;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [AREA_W-1:0] AREA_TOP  = {AREA_W{1'b1}};
    localparam logic [AREA_W-1:0] AREA_FULL = AREA_W'(32767 * 32767);

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        opcode;
    logic [EDGE_W-1:0] rect_x;
    logic [EDGE_W-1:0] rect_y;
    logic [EDGE_W-1:0] rect_w;
    logic [EDGE_W-1:0] rect_h;
    logic              out_valid;
    logic              out_stall;
    logic [EDGE_W-1:0] out_x;
    logic [EDGE_W-1:0] out_y;
    logic [EDGE_W-1:0] out_w;
    logic [EDGE_W-1:0] out_h;
    logic              found;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [AREA_W-1:0] cfg_data;

    int fails;
    int waiting;
    int idle_cycles;
    bit steady;
    bit hold_req;
    bit hold_done;
    int stall_left;

    // copy of the loaded boxes, used to aim queries at them and to count accepted loads
    int shadow_n;
    int shadow_x [MAX_BOXES];
    int shadow_y [MAX_BOXES];
    int shadow_w [MAX_BOXES];
    int shadow_h [MAX_BOXES];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    contained_box_union_query_core #(.MAX_BOXES(MAX_BOXES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .rect_x    (rect_x),
        .rect_y    (rect_y),
        .rect_w    (rect_w),
        .rect_h    (rect_h),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_w     (out_w),
        .out_h     (out_h),
        .found     (found),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    box_union_checker #(.MAX_BOXES(MAX_BOXES)) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .rect_x    (rect_x),
        .rect_y    (rect_y),
        .rect_w    (rect_w),
        .rect_h    (rect_h),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_w     (out_w),
        .out_h     (out_h),
        .found     (found),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .waiting   (waiting)
    );

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_stall  = 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall  = (stall_left > 0);
                if (stall_left > 0)
                    stall_left = stall_left - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [1:0] op, input logic [EDGE_W-1:0] x,
                             input logic [EDGE_W-1:0] y, input logic [EDGE_W-1:0] w,
                             input logic [EDGE_W-1:0] h);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode   = op;
        rect_x   = x;
        rect_y   = y;
        rect_w   = w;
        rect_h   = h;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_CLEAR)
            shadow_n = 0;
        else if (op == OP_LOAD && shadow_n < MAX_BOXES)
        begin
            shadow_x[shadow_n] = x;
            shadow_y[shadow_n] = y;
            shadow_w[shadow_n] = w;
            shadow_h[shadow_n] = h;
            shadow_n++;
        end
    endtask

    // drop valid and wait until every query has answered and the core is quiet
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_area_floor(input logic [AREA_W-1:0] value);
        @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_random_box();
        if ($urandom_range(0, 3) == 0)
            push_item(OP_LOAD, EDGE_W'($urandom), EDGE_W'($urandom),
                      EDGE_W'($urandom), EDGE_W'($urandom));
        else
            push_item(OP_LOAD, EDGE_W'($urandom_range(0, 1023)),
                      EDGE_W'($urandom_range(0, 1023)),
                      EDGE_W'($urandom_range(0, 63)), EDGE_W'($urandom_range(0, 63)));
    endtask

    // aim most queries around a stored box so that containment is reached
    task automatic query_random();
        int pick;
        int i;
        int lo_x;
        int lo_y;
        int hi_x;
        int hi_y;
        pick = $urandom_range(0, 9);
        if (shadow_n > 0 && pick < 6)
        begin
            i    = $urandom_range(0, shadow_n - 1);
            lo_x = shadow_x[i] - (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300));
            lo_y = shadow_y[i] - (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300));
            if (lo_x < 0) lo_x = 0;
            if (lo_y < 0) lo_y = 0;
            hi_x = shadow_x[i] + shadow_w[i] +
                   (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300));
            hi_y = shadow_y[i] + shadow_h[i] +
                   (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300));
            // shave one pixel off now and then to hit the boundary
            if ($urandom_range(0, 7) == 0) hi_x = hi_x - 1;
            if (hi_x < lo_x) hi_x = lo_x;
            if (hi_y < lo_y) hi_y = lo_y;
            if (hi_x > lo_x + 32767) hi_x = lo_x + 32767;
            if (hi_y > lo_y + 32767) hi_y = lo_y + 32767;
            push_item(OP_QUERY, EDGE_W'(lo_x), EDGE_W'(lo_y),
                      EDGE_W'(hi_x - lo_x), EDGE_W'(hi_y - lo_y));
        end
        else if (pick == 6)
            push_item(OP_QUERY, '0, '0, EDGE_MAX, EDGE_MAX);
        else if (pick == 7)
            push_item(OP_QUERY, EDGE_W'($urandom_range(0, 512)),
                      EDGE_W'($urandom_range(0, 512)),
                      EDGE_W'($urandom_range(0, 1024)), EDGE_W'($urandom_range(0, 1024)));
        else
            push_item(OP_QUERY, EDGE_W'($urandom), EDGE_W'($urandom),
                      EDGE_W'($urandom), EDGE_W'($urandom));
    endtask

    task automatic run_random(input int item_goal, input bit fill_table);
        int done;
        int r;
        int k;
        done = 0;
        if (fill_table)
        begin
            push_item(OP_CLEAR, '0, '0, '0, '0);
            // the last few loads land on a full table and are dropped
            repeat (MAX_BOXES + 4) load_random_box();
            repeat (6) query_random();
            done = MAX_BOXES + 7;
        end
        while (done < item_goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                push_item(OP_UNUSED, EDGE_W'($urandom), EDGE_W'($urandom),
                          EDGE_W'($urandom), EDGE_W'($urandom));
            else if (r < 12)
            begin
                query_random();
                done++;
            end
            else
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    push_item(OP_CLEAR, EDGE_W'($urandom), EDGE_W'($urandom),
                              EDGE_W'($urandom), EDGE_W'($urandom));
                    done++;
                end
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
                repeat (k)
                begin
                    if (shadow_n < MAX_BOXES)
                        done++;
                    load_random_box();
                end
                k = $urandom_range(1, 4);
                repeat (k) query_random();
                done += k;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = OP_CLEAR;
        rect_x      = '0;
        rect_y      = '0;
        rect_w      = '0;
        rect_h      = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        shadow_n    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, area floor at its reset value
        push_item(OP_QUERY, 15'd100, 15'd200, 15'd300, 15'd400);
        push_item(OP_CLEAR, '0, '0, '0, '0);
        push_item(OP_LOAD, EDGE_MAX, EDGE_MAX, EDGE_MAX, EDGE_MAX);
        push_item(OP_LOAD, '0, '0, '0, '0);
        push_item(OP_LOAD, '0, '0, EDGE_MAX, EDGE_MAX);
        push_item(OP_LOAD, 15'd10, 15'd20, 15'd8, 15'd4);
        push_item(OP_LOAD, 15'd10, 15'd20, 15'd31, 15'd1);
        push_item(OP_UNUSED, EDGE_MAX, EDGE_MAX, EDGE_MAX, EDGE_MAX);
        push_item(OP_QUERY, '0, '0, EDGE_MAX, EDGE_MAX);
        push_item(OP_QUERY, EDGE_MAX, EDGE_MAX, EDGE_MAX, EDGE_MAX);
        push_item(OP_QUERY, 15'd10, 15'd20, 15'd8, 15'd4);
        push_item(OP_QUERY, 15'd11, 15'd20, 15'd8, 15'd4);
        push_item(OP_QUERY, 15'd10, 15'd20, 15'd7, 15'd4);
        push_item(OP_QUERY, '0, '0, '0, '0);
        push_item(OP_CLEAR, '0, '0, '0, '0);
        push_item(OP_QUERY, '0, '0, EDGE_MAX, EDGE_MAX);
        settle();

        // zero-area boxes take part once the area floor is zero
        write_area_floor('0);
        push_item(OP_LOAD, 15'd5, 15'd5, '0, '0);
        push_item(OP_LOAD, 15'd7, 15'd3, '0, 15'd9);
        push_item(OP_QUERY, '0, '0, 15'd10, 15'd15);
        push_item(OP_QUERY, 15'd6, '0, 15'd10, 15'd15);
        settle();

        write_area_floor(AREA_W'(1));
        run_random(100, 1'b0);
        settle();

        // fill the core while results are held back
        write_area_floor(AREA_FLOOR_RESET);
        hold_req = 1'b1;
        push_item(OP_CLEAR, '0, '0, '0, '0);
        repeat (4) load_random_box();
        repeat (24) query_random();
        run_random(60, 1'b0);
        settle();

        write_area_floor(AREA_W'(1));
        run_random(MAX_BOXES + 20, 1'b1);
        settle();

        steady = 1'b1;
        write_area_floor(AREA_W'(1000));
        run_random(80, 1'b0);
        settle();
        steady = 1'b0;

        write_area_floor(AREA_W'($urandom));
        run_random(40, 1'b0);
        settle();

        write_area_floor(AREA_FULL);
        push_item(OP_CLEAR, '0, '0, '0, '0);
        push_item(OP_LOAD, '0, '0, EDGE_MAX, EDGE_MAX);
        push_item(OP_LOAD, '0, '0, EDGE_MAX, 15'd32766);
        push_item(OP_QUERY, '0, '0, EDGE_MAX, EDGE_MAX);
        run_random(30, 1'b0);
        settle();

        write_area_floor(AREA_TOP);
        run_random(40, 1'b0);
        settle();

        write_area_floor('0);
        run_random(80, 1'b0);
        settle();

        write_area_floor(AREA_W'(64));
        run_random(80, 1'b0);
        settle();

        if (fails == 0 && waiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
